/* hdl/mdcq_pkg.sv */
// Shared types and constants for the mouse double-click qualifier.
`default_nettype none

package mdcq_pkg;

    localparam int BUTTONS      = 3;
    localparam int DELAY_FACTOR = 5;
    localparam int SLOTS        = 2 * BUTTONS + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOUBLE_ENABLE  = 3'd0,
        CFG_ALT_DOUBLE     = 3'd1,
        CFG_CLICK_TIME     = 3'd2,
        CFG_CLICK_DELAY    = 3'd3,
        CFG_MOVE_TOLERANCE = 3'd4
    } cfg_idx_t;

    localparam logic [15:0] MOVE_TOL_RESET = 16'd5;

    typedef struct packed {
        logic [BUTTONS-1:0] double_enable;
        logic               alt_double;
        logic [15:0]        click_time;
        logic [15:0]        click_delay;
        logic [15:0]        move_tolerance;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        stamp;
        logic [BUTTONS-1:0] press_bits;
        logic [BUTTONS-1:0] release_bits;
        logic [BUTTONS-1:0] double_bits;
        logic [7:0]         held_buttons;
        logic               alt_down;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [31:0]        out_stamp;
        logic [BUTTONS-1:0] out_press;
        logic [BUTTONS-1:0] out_release;
        logic [BUTTONS-1:0] out_double;
        logic [7:0]         out_held;
        logic               last;
    } out_item_t;

    // one event held back or sent on
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        stamp;
        logic [BUTTONS-1:0] press_bits;
        logic [BUTTONS-1:0] rel_bits;
        logic [BUTTONS-1:0] dbl_bits;
        logic [7:0]         held;
    } kept_t;

endpackage

`default_nettype wire

/* hdl/mdcq_cfg.sv */
// Configuration register file for the double-click qualifier.
`default_nettype none

module mdcq_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mdcq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mdcq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mdcq_pkg::cfg_t                          cfg
);

    mdcq_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_enable  <= '0;
            cfg_reg.alt_double     <= 1'b0;
            cfg_reg.click_time     <= '0;
            cfg_reg.click_delay    <= '0;
            cfg_reg.move_tolerance <= mdcq_pkg::MOVE_TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mdcq_pkg::CFG_DOUBLE_ENABLE:
                    cfg_reg.double_enable <= cfg_data[mdcq_pkg::BUTTONS-1:0];
                mdcq_pkg::CFG_ALT_DOUBLE:
                    cfg_reg.alt_double <= cfg_data[0];
                mdcq_pkg::CFG_CLICK_TIME:
                    cfg_reg.click_time <= cfg_data;
                mdcq_pkg::CFG_CLICK_DELAY:
                    cfg_reg.click_delay <= cfg_data;
                mdcq_pkg::CFG_MOVE_TOLERANCE:
                    cfg_reg.move_tolerance <= cfg_data;
                default:
                    ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/mdcq_eval.sv */
// Input register, per-button click slots and the flush and event passes over one event.
`default_nettype none

module mdcq_eval (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mdcq_pkg::cfg_t                     cfg,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire mdcq_pkg::in_item_t                 in_data,
    input  wire logic                               can_load,
    output logic                                    load,
    output logic [mdcq_pkg::SLOTS-1:0]              load_mask,
    output mdcq_pkg::kept_t [mdcq_pkg::SLOTS-1:0]   load_data
);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_HELD  = 2'd1,
        ST_SENT  = 2'd2
    } slot_st_t;

    localparam int NB = mdcq_pkg::BUTTONS;

    logic                in_reg_valid;
    mdcq_pkg::in_item_t  in_reg;
    logic                accept;

    slot_st_t            pst_reg  [NB];
    slot_st_t            pst_next [NB];
    slot_st_t            rst_reg  [NB];
    slot_st_t            rst_next [NB];
    mdcq_pkg::kept_t     pkept_reg  [NB];
    mdcq_pkg::kept_t     pkept_next [NB];
    mdcq_pkg::kept_t     rkept_reg  [NB];
    mdcq_pkg::kept_t     rkept_next [NB];

    logic [16:0]         dx_w  [NB];
    logic [16:0]         dy_w  [NB];
    logic [16:0]         mx_w  [NB];
    logic [16:0]         my_w  [NB];
    logic [31:0]         page_w [NB];
    logic [31:0]         rage_w [NB];
    logic [NB-1:0]       moved_w;
    logic [NB-1:0]       pdue_w;
    logic [NB-1:0]       rdue_w;
    logic [31:0]         delay_lim;

    logic [NB-1:0]       pr_w;
    logic [NB-1:0]       db_w;
    logic                eaten_w;
    mdcq_pkg::kept_t     cur_w;

    assign accept   = in_valid && !in_stall;
    assign in_stall = in_reg_valid && !can_load;
    assign load     = in_reg_valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg_valid <= 1'b0;
        end
        else if (accept)
        begin
            in_reg_valid <= 1'b1;
        end
        else if (load)
        begin
            in_reg_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
    end

    // 5 * click_delay, at most 19 bits
    assign delay_lim = 32'({cfg.click_delay, 2'b00}) + 32'(cfg.click_delay);

    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            dx_w[i] = {in_reg.pos_x[15], in_reg.pos_x} -
                      {pkept_reg[i].pos_x[15], pkept_reg[i].pos_x};
            dy_w[i] = {in_reg.pos_y[15], in_reg.pos_y} -
                      {pkept_reg[i].pos_y[15], pkept_reg[i].pos_y};
            mx_w[i] = dx_w[i][16] ? (~dx_w[i] + 17'd1) : dx_w[i];
            my_w[i] = dy_w[i][16] ? (~dy_w[i] + 17'd1) : dy_w[i];
            moved_w[i] = (mx_w[i] > {1'b0, cfg.move_tolerance}) ||
                         (my_w[i] > {1'b0, cfg.move_tolerance});
            page_w[i] = in_reg.stamp - pkept_reg[i].stamp;
            rage_w[i] = in_reg.stamp - rkept_reg[i].stamp;
            pdue_w[i] = moved_w[i] || (page_w[i] >= delay_lim);
            rdue_w[i] = moved_w[i] || (rage_w[i] >= 32'(cfg.click_time));
        end
    end

    always_comb
    begin
        pst_next   = pst_reg;
        rst_next   = rst_reg;
        pkept_next = pkept_reg;
        rkept_next = rkept_reg;
        load_mask  = '0;
        pr_w       = in_reg.press_bits;
        db_w       = in_reg.double_bits;
        eaten_w    = 1'b0;

        // flush pass: buttons are independent here
        for (int i = 0; i < NB; i++)
        begin
            load_data[2*i]   = pkept_reg[i];
            load_data[2*i+1] = rkept_reg[i];
            if (cfg.double_enable[i] && pst_reg[i] != ST_EMPTY)
            begin
                if (pdue_w[i])
                begin
                    if (pst_reg[i] == ST_HELD)
                    begin
                        pst_next[i]    = ST_SENT;
                        load_mask[2*i] = 1'b1;
                    end
                    if (rst_reg[i] == ST_HELD)
                    begin
                        rst_next[i]      = ST_SENT;
                        load_mask[2*i+1] = 1'b1;
                    end
                end
                if (rst_reg[i] != ST_EMPTY && rdue_w[i])
                begin
                    pst_next[i] = ST_EMPTY;
                    rst_next[i] = ST_EMPTY;
                end
            end
        end

        // event pass: kept records see bits already changed by lower buttons
        if (!in_reg.mode)
        begin
            for (int i = 0; i < NB; i++)
            begin
                if (cfg.double_enable[i])
                begin
                    if (cfg.alt_double && in_reg.alt_down && pr_w[i])
                    begin
                        pr_w[i] = 1'b0;
                        db_w[i] = 1'b1;
                    end
                    else if (pst_next[i] != ST_EMPTY)
                    begin
                        if (pr_w[i])
                        begin
                            pr_w[i]     = 1'b0;
                            db_w[i]     = 1'b1;
                            pst_next[i] = ST_EMPTY;
                            rst_next[i] = ST_EMPTY;
                        end
                        if (in_reg.release_bits[i])
                        begin
                            rst_next[i] = ST_HELD;
                            rkept_next[i] = '{pos_x: in_reg.pos_x, pos_y: in_reg.pos_y,
                                              stamp: in_reg.stamp, press_bits: pr_w,
                                              rel_bits: in_reg.release_bits,
                                              dbl_bits: db_w, held: in_reg.held_buttons};
                            eaten_w = 1'b1;
                        end
                    end
                    else if (pr_w[i])
                    begin
                        pst_next[i] = ST_HELD;
                        pkept_next[i] = '{pos_x: in_reg.pos_x, pos_y: in_reg.pos_y,
                                          stamp: in_reg.stamp, press_bits: pr_w,
                                          rel_bits: in_reg.release_bits,
                                          dbl_bits: db_w, held: in_reg.held_buttons};
                        eaten_w = 1'b1;
                    end
                end
            end
        end

        cur_w = '{pos_x: in_reg.pos_x, pos_y: in_reg.pos_y, stamp: in_reg.stamp,
                  press_bits: pr_w, rel_bits: in_reg.release_bits,
                  dbl_bits: db_w, held: in_reg.held_buttons};
        load_data[mdcq_pkg::SLOTS-1] = cur_w;
        load_mask[mdcq_pkg::SLOTS-1] = !in_reg.mode && !eaten_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
            begin
                pst_reg[i] <= ST_EMPTY;
                rst_reg[i] <= ST_EMPTY;
            end
        end
        else if (load)
        begin
            pst_reg <= pst_next;
            rst_reg <= rst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkept_reg <= pkept_next;
            rkept_reg <= rkept_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/mdcq_resq.sv */
// Result slots of one event, sent lowest slot first, one beat a cycle while out_stall is low.
`default_nettype none

module mdcq_resq (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic [mdcq_pkg::SLOTS-1:0]         load_mask,
    input  wire mdcq_pkg::kept_t [mdcq_pkg::SLOTS-1:0] load_data,
    output logic                                    can_load,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output mdcq_pkg::out_item_t                     out_data
);

    localparam int NS = mdcq_pkg::SLOTS;

    logic [NS-1:0]                   mask_reg;
    logic [NS-1:0]                   mask_next;
    mdcq_pkg::kept_t [NS-1:0]        data_reg;
    logic [NS-1:0]                   head;
    logic [NS-1:0]                   remain;
    logic                            take;
    mdcq_pkg::kept_t                 sel;

    assign head      = mask_reg & (~mask_reg + NS'(1));
    assign out_valid = |mask_reg;
    assign take      = out_valid && !out_stall;
    assign remain    = take ? (mask_reg & ~head) : mask_reg;
    assign can_load  = (remain == '0);
    assign mask_next = load ? load_mask : remain;

    always_comb
    begin
        sel = '0;
        for (int s = 0; s < NS; s++)
        begin
            if (head[s])
            begin
                sel = sel | data_reg[s];
            end
        end
    end

    always_comb
    begin
        out_data.out_x       = sel.pos_x;
        out_data.out_y       = sel.pos_y;
        out_data.out_stamp   = sel.stamp;
        out_data.out_press   = sel.press_bits;
        out_data.out_release = sel.rel_bits;
        out_data.out_double  = sel.dbl_bits;
        out_data.out_held    = sel.held;
        out_data.last        = ((mask_reg & ~head) == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/mouse_double_click_qualifier.sv */
// Mouse double-click qualifier: top level.
// Path: an event goes into the input register, then to the result slots once free.
// Throughput: an event with N results (0 to 7) sends them in turn on the single
// result port; events giving at most one result each go through one per cycle while
// out_stall is low. Reset: slot status and configuration take their defaults
// at once; kept event payload is not reset and is only read once its slot has been filled.
`default_nettype none

module mouse_double_click_qualifier (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire mdcq_pkg::in_item_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output mdcq_pkg::out_item_t                     out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mdcq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mdcq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mdcq_pkg::cfg_t                              cfg;
    logic                                        can_load;
    logic                                        load;
    logic [mdcq_pkg::SLOTS-1:0]                  load_mask;
    mdcq_pkg::kept_t [mdcq_pkg::SLOTS-1:0]       load_data;

    mdcq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mdcq_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .can_load  (can_load),
        .load      (load),
        .load_mask (load_mask),
        .load_data (load_data)
    );

    mdcq_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_mask (load_mask),
        .load_data (load_data),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* hdl/mdcq_checker.sv */
// Port-level checks for the double-click qualifier, bound to the top level.
`default_nettype none

module mdcq_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_stall,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire mdcq_pkg::out_item_t                out_data,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // input only backs up behind pending results
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_idle_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output idle");

    // results of one event come as an unbroken run ending in last
    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last |=> out_valid)
        else $error("result run broken before last beat");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind mouse_double_click_qualifier mdcq_checker u_mdcq_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the mouse double-click qualifier: directed and random mouse beats.
`timescale 1ns / 1ps

module testbench;

    localparam int NB = mdcq_pkg::BUTTONS;
    localparam logic                           MODE_EVENT    = 1'b0;
    localparam logic                           MODE_POLL     = 1'b1;
    localparam logic [mdcq_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int                             SETTLE_CYCLES = 8;
    localparam int                             TIMEOUT_NS    = 2_000_000;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_HELD  = 2'd1,
        SLOT_SENT  = 2'd2
    } slot_state_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    mdcq_pkg::in_item_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    mdcq_pkg::out_item_t             out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mdcq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mdcq_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    mdcq_pkg::cfg_t  cur_cfg;
    slot_state_t     press_slot [NB];
    slot_state_t     release_slot [NB];
    mdcq_pkg::kept_t press_kept [NB];
    mdcq_pkg::kept_t release_kept [NB];

    mdcq_pkg::in_item_t  pending [$];
    mdcq_pkg::out_item_t events_due [$];

    int items_taken   = 0;
    int beats_checked = 0;
    int mismatches    = 0;
    int reg_writes    = 0;
    int send_gap      = 0;
    int send_calm     = 0;
    int hold_left     = 0;
    int hold_calm     = 0;
    mdcq_pkg::out_item_t want;
    logic        field_bad;
    logic [31:0] now_t = 32'd100000;
    logic [15:0] cx    = '0;
    logic [15:0] cy    = '0;

    mouse_double_click_qualifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    function automatic mdcq_pkg::in_item_t compose_event(logic mode, logic [15:0] x,
                                               logic [15:0] y,
                                               logic [31:0] stamp, logic [NB-1:0] pr,
                                               logic [NB-1:0] rl, logic [NB-1:0] db,
                                               logic [7:0] held, logic alt);
        mdcq_pkg::in_item_t it;
        it.mode         = mode;
        it.pos_x        = x;
        it.pos_y        = y;
        it.stamp        = stamp;
        it.press_bits   = pr;
        it.release_bits = rl;
        it.double_bits  = db;
        it.held_buttons = held;
        it.alt_down     = alt;
        return it;
    endfunction

    function automatic string show_event(mdcq_pkg::out_item_t e);
        return $sformatf("x=%0d y=%0d t=%h p=%b r=%b d=%b h=%h last=%b", e.out_x, e.out_y,
                         e.out_stamp, e.out_press, e.out_release, e.out_double, e.out_held,
                         e.last);
    endfunction

    function automatic void take_register(logic [mdcq_pkg::CFG_IDX_W-1:0] idx,
                                          logic [mdcq_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mdcq_pkg::CFG_DOUBLE_ENABLE:  cur_cfg.double_enable  = data[NB-1:0];
            mdcq_pkg::CFG_ALT_DOUBLE:     cur_cfg.alt_double     = data[0];
            mdcq_pkg::CFG_CLICK_TIME:     cur_cfg.click_time     = data;
            mdcq_pkg::CFG_CLICK_DELAY:    cur_cfg.click_delay    = data;
            mdcq_pkg::CFG_MOVE_TOLERANCE: cur_cfg.move_tolerance = data;
            default: ;
        endcase
    endfunction

    function automatic mdcq_pkg::kept_t keep(mdcq_pkg::in_item_t it, logic [NB-1:0] pr,
                                   logic [NB-1:0] rl, logic [NB-1:0] db);
        mdcq_pkg::kept_t k;
        k.pos_x      = it.pos_x;
        k.pos_y      = it.pos_y;
        k.stamp      = it.stamp;
        k.press_bits = pr;
        k.rel_bits   = rl;
        k.dbl_bits   = db;
        k.held       = it.held_buttons;
        return k;
    endfunction

    function automatic mdcq_pkg::out_item_t sent_on(mdcq_pkg::kept_t k);
        mdcq_pkg::out_item_t o;
        o.out_x       = k.pos_x;
        o.out_y       = k.pos_y;
        o.out_stamp   = k.stamp;
        o.out_press   = k.press_bits;
        o.out_release = k.rel_bits;
        o.out_double  = k.dbl_bits;
        o.out_held    = k.held;
        o.last        = 1'b0;
        return o;
    endfunction

    function automatic int axis_gap(logic signed [15:0] a, logic signed [15:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    // flush kept clicks, then qualify the beat itself
    function automatic void qualify_event(mdcq_pkg::in_item_t it);
        mdcq_pkg::out_item_t batch [mdcq_pkg::SLOTS];
        int                  n;
        int                  tol;
        logic [NB-1:0]       pr;
        logic [NB-1:0]       rl;
        logic [NB-1:0]       db;
        logic [31:0]         delay_span;
        logic [31:0]         press_age;
        logic [31:0]         release_age;
        logic                moved;
        logic                kept_any;
        n          = 0;
        pr         = it.press_bits;
        rl         = it.release_bits;
        db         = it.double_bits;
        kept_any   = 1'b0;
        tol        = int'({16'd0, cur_cfg.move_tolerance});
        delay_span = 32'(cur_cfg.click_delay) * 32'(mdcq_pkg::DELAY_FACTOR);
        for (int b = 0; b < NB; b++)
        begin
            if (cur_cfg.double_enable[b] && press_slot[b] != SLOT_EMPTY)
            begin
                moved = axis_gap(it.pos_x, press_kept[b].pos_x) > tol ||
                        axis_gap(it.pos_y, press_kept[b].pos_y) > tol;
                press_age = it.stamp - press_kept[b].stamp;
                if (moved || press_age >= delay_span)
                begin
                    if (press_slot[b] == SLOT_HELD)
                    begin
                        press_slot[b] = SLOT_SENT;
                        batch[n] = sent_on(press_kept[b]);
                        n++;
                    end
                    if (release_slot[b] == SLOT_HELD)
                    begin
                        release_slot[b] = SLOT_SENT;
                        batch[n] = sent_on(release_kept[b]);
                        n++;
                    end
                end
                if (release_slot[b] != SLOT_EMPTY)
                begin
                    release_age = it.stamp - release_kept[b].stamp;
                    if (moved || release_age >= {16'd0, cur_cfg.click_time})
                    begin
                        press_slot[b]   = SLOT_EMPTY;
                        release_slot[b] = SLOT_EMPTY;
                    end
                end
            end
        end
        if (it.mode == MODE_EVENT)
        begin
            for (int b = 0; b < NB; b++)
            begin
                if (cur_cfg.double_enable[b])
                begin
                    if (cur_cfg.alt_double && it.alt_down && pr[b])
                    begin
                        pr[b] = 1'b0;
                        db[b] = 1'b1;
                    end
                    else if (press_slot[b] != SLOT_EMPTY)
                    begin
                        if (pr[b])
                        begin
                            pr[b]           = 1'b0;
                            db[b]           = 1'b1;
                            press_slot[b]   = SLOT_EMPTY;
                            release_slot[b] = SLOT_EMPTY;
                        end
                        if (rl[b])
                        begin
                            release_slot[b] = SLOT_HELD;
                            release_kept[b] = keep(it, pr, rl, db);
                            kept_any        = 1'b1;
                        end
                    end
                    else if (pr[b])
                    begin
                        press_slot[b] = SLOT_HELD;
                        press_kept[b] = keep(it, pr, rl, db);
                        kept_any      = 1'b1;
                    end
                end
            end
            if (!kept_any)
            begin
                batch[n] = sent_on(keep(it, pr, rl, db));
                n++;
            end
        end
        if (n > 0)
            batch[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            events_due.push_back(batch[k]);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                qualify_event(in_data);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    in_data  <= pending.pop_front();
                    in_valid <= 1'b1;
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = $urandom_range(0, 11);
                        if ($urandom_range(0, 15) == 0)
                            send_calm = $urandom_range(8, 24);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_checked++;
                if (events_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %s", show_event(out_data));
                end
                else
                begin
                    want = events_due.pop_front();
                    field_bad = out_data.out_x !== want.out_x ||
                                out_data.out_y !== want.out_y ||
                                out_data.out_stamp !== want.out_stamp ||
                                out_data.out_press !== want.out_press ||
                                out_data.out_release !== want.out_release ||
                                out_data.out_double !== want.out_double ||
                                out_data.out_held !== want.out_held ||
                                out_data.last !== want.last;
                    if (field_bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch on result beat %0d: expected %s, got %s",
                                     beats_checked, show_event(want), show_event(out_data));
                    end
                end
                if (hold_calm > 0)
                begin
                    hold_calm--;
                    hold_left = 0;
                end
                else
                begin
                    hold_left = $urandom_range(0, 11);
                    if ($urandom_range(0, 15) == 0)
                        hold_calm = $urandom_range(8, 24);
                end
            end
            else if (hold_left > 0)
                hold_left--;
            out_stall <= (hold_left != 0);
        end
    end

    task automatic drain_results();
        do
            @(negedge clk);
        while (pending.size() != 0 || in_valid || events_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [mdcq_pkg::CFG_IDX_W-1:0] idx,
                             logic [mdcq_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        take_register(idx, data);
        reg_writes++;
    endtask

    task automatic set_config(logic [NB-1:0] enable, logic alt, logic [15:0] ctime,
                              logic [15:0] cdelay, logic [15:0] tol);
        write_reg(mdcq_pkg::CFG_DOUBLE_ENABLE, 16'(enable));
        write_reg(mdcq_pkg::CFG_ALT_DOUBLE, 16'(alt));
        write_reg(mdcq_pkg::CFG_CLICK_TIME, ctime);
        write_reg(mdcq_pkg::CFG_CLICK_DELAY, cdelay);
        write_reg(mdcq_pkg::CFG_MOVE_TOLERANCE, tol);
        @(negedge clk);
    endtask

    function automatic logic [31:0] tick_step();
        case ($urandom_range(0, 5))
            0:       return 32'($urandom_range(0, 3));
            1, 2:    return 32'($urandom_range(0, int'(cur_cfg.click_time) + 2));
            3, 4:    return 32'($urandom_range(0, 5 * int'(cur_cfg.click_delay) + 2));
            default: return $urandom;
        endcase
    endfunction

    // small jitter, moves right at the tolerance edge, or a wild jump
    function automatic logic [15:0] nudge(logic [15:0] c);
        int d;
        case ($urandom_range(0, 7))
            0, 1, 2: d = 0;
            3, 4:    d = int'($urandom_range(0, 6)) - 3;
            5, 6:    d = int'({16'd0, cur_cfg.move_tolerance}) + int'($urandom_range(0, 1));
            default: d = int'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 1) == 1)
            d = -d;
        return c + 16'(d);
    endfunction

    task automatic run_random(int count, bit pause_midway);
        int            made;
        int            kind;
        int            presses;
        bit            paused;
        logic [NB-1:0] bits;
        logic [NB-1:0] dbl;
        logic [7:0]    held;
        logic          alt;
        made   = 0;
        paused = 1'b0;
        while (made < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                bits = NB'(1 << $urandom_range(0, NB - 1));
                if ($urandom_range(0, 4) == 0)
                    bits = bits | NB'($urandom);
                alt     = ($urandom_range(0, 4) == 0);
                held    = 8'($urandom);
                presses = $urandom_range(1, 2);
                for (int k = 0; k < presses; k++)
                begin
                    dbl = ($urandom_range(0, 5) == 0) ? NB'($urandom) : '0;
                    pending.push_back(compose_event(MODE_EVENT, cx, cy, now_t, bits, '0, dbl,
                                                    held, alt));
                    now_t = now_t + tick_step();
                    cx    = nudge(cx);
                    cy    = nudge(cy);
                    pending.push_back(compose_event(MODE_EVENT, cx, cy, now_t, '0, bits, '0,
                                                    held, alt));
                    now_t = now_t + tick_step();
                    cx    = nudge(cx);
                    cy    = nudge(cy);
                    made += 2;
                end
            end
            else if (kind < 8)
            begin
                pending.push_back(compose_event(MODE_POLL, cx, cy, now_t, NB'($urandom),
                                                NB'($urandom), NB'($urandom),
                                                8'($urandom), 1'($urandom)));
                now_t = now_t + tick_step();
                cx    = nudge(cx);
                cy    = nudge(cy);
                made++;
            end
            else if (kind == 8)
            begin
                pending.push_back(compose_event(1'($urandom), 16'($urandom), 16'($urandom),
                                                $urandom, NB'($urandom),
                                                NB'($urandom), NB'($urandom),
                                                8'($urandom), 1'($urandom)));
                made++;
            end
            else
            begin
                cx    = 16'($urandom);
                cy    = 16'($urandom);
                now_t = now_t + $urandom;
                pending.push_back(compose_event(MODE_POLL, cx, cy, now_t, '0, '0, '0, '0,
                                                1'b0));
                made++;
            end
            if (pause_midway && !paused && made >= count / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        cur_cfg = '{double_enable: '0, alt_double: 1'b0, click_time: '0, click_delay: '0,
                    move_tolerance: mdcq_pkg::MOVE_TOL_RESET};
        for (int b = 0; b < NB; b++)
        begin
            press_slot[b]   = SLOT_EMPTY;
            release_slot[b] = SLOT_EMPTY;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // detection off: everything passes straight through, poll gives nothing
        pending.push_back(compose_event(MODE_EVENT, 16'h8000, 16'h7FFF, 32'd0, 3'b111, 3'b111,
                                        3'b111, 8'hFF, 1'b1));
        pending.push_back(compose_event(MODE_POLL, 16'h7FFF, 16'h8000, 32'd5, '0, '0, '0,
                                        8'h00, 1'b0));
        drain_results();

        set_config(3'b111, 1'b0, 16'd100, 16'd20, 16'd5);
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        @(negedge clk);
        // press, release, second press turns into a double, then a plain release
        pending.push_back(compose_event(MODE_EVENT, 16'd10, 16'd10, 32'd1000, 3'b001, '0, '0,
                                        8'h01, 1'b0));
        pending.push_back(compose_event(MODE_EVENT, 16'd12, 16'd12, 32'd1010, '0, 3'b001, '0,
                                        8'h00, 1'b0));
        pending.push_back(compose_event(MODE_EVENT, 16'd13, 16'd11, 32'd1020, 3'b001, '0, '0,
                                        8'h01, 1'b0));
        pending.push_back(compose_event(MODE_EVENT, 16'd13, 16'd11, 32'd1030, '0, 3'b001, '0,
                                        8'h00, 1'b0));
        // pointer moves away: press sent alone, empty release slot stays quiet
        pending.push_back(compose_event(MODE_EVENT, 16'd0, 16'd0, 32'd2000, 3'b010, '0, '0,
                                        8'h02, 1'b0));
        pending.push_back(compose_event(MODE_POLL, 16'd6, 16'd0, 32'd2001, '0, '0, '0,
                                        8'h00, 1'b0));
        pending.push_back(compose_event(MODE_EVENT, 16'd6, 16'd0, 32'd2002, '0, 3'b010, '0,
                                        8'h00, 1'b0));
        pending.push_back(compose_event(MODE_POLL, 16'd6, 16'd0, 32'd2003, '0, '0, '0,
                                        8'h00, 1'b0));
        // press ages out: pair sent, then dropped once the release is old enough
        pending.push_back(compose_event(MODE_EVENT, 16'd100, 16'd100, 32'd3000, 3'b100, '0,
                                        '0, 8'h04, 1'b0));
        pending.push_back(compose_event(MODE_EVENT, 16'd100, 16'd100, 32'd3005, '0, 3'b100,
                                        '0, 8'h00, 1'b0));
        pending.push_back(compose_event(MODE_POLL, 16'd100, 16'd100, 32'd3100, '0, '0, '0,
                                        8'h00, 1'b0));
        pending.push_back(compose_event(MODE_POLL, 16'd100, 16'd100, 32'd3105, '0, '0, '0,
                                        8'h00, 1'b0));
        // several buttons in one beat: kept records carry bits changed so far
        pending.push_back(compose_event(MODE_EVENT, 16'd50, 16'd50, 32'd4000, 3'b011, '0, '0,
                                        8'h03, 1'b0));
        pending.push_back(compose_event(MODE_EVENT, 16'd50, 16'd50, 32'd4001, '0, 3'b011, '0,
                                        8'h00, 1'b0));
        pending.push_back(compose_event(MODE_EVENT, 16'd50, 16'd50, 32'd4002, 3'b111, '0, '0,
                                        8'h07, 1'b0));
        pending.push_back(compose_event(MODE_POLL, 16'd50, 16'd50, 32'hFFFF_FFF0, '0, '0, '0,
                                        8'h00, 1'b0));
        drain_results();

        // alt doubling, then a kept press across the stamp wrap
        set_config(3'b111, 1'b1, 16'd100, 16'd20, 16'd5);
        pending.push_back(compose_event(MODE_EVENT, 16'd50, 16'd50, 32'd5000, 3'b001, 3'b001,
                                        '0, 8'h01, 1'b1));
        pending.push_back(compose_event(MODE_EVENT, 16'd0, 16'd0, 32'hFFFF_FFFF, 3'b001, '0,
                                        '0, 8'h01, 1'b0));
        pending.push_back(compose_event(MODE_POLL, 16'd0, 16'd0, 32'h0000_0010, '0, '0, '0,
                                        8'h00, 1'b0));
        pending.push_back(compose_event(MODE_POLL, 16'd0, 16'd0, 32'h0000_0063, '0, '0, '0,
                                        8'h00, 1'b0));
        drain_results();

        set_config(3'b111, 1'b0, 16'd50, 16'd10, 16'd5);
        run_random(30, 1'b1);
        drain_results();
        set_config(3'b111, 1'b1, 16'd0, 16'd0, 16'd0);
        run_random(30, 1'b0);
        drain_results();
        set_config(NB'($urandom_range(1, 6)), 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(30, 1'b0);
        drain_results();
        set_config(NB'($urandom), 1'($urandom), 16'($urandom_range(0, 300)),
                   16'($urandom_range(0, 60)), 16'($urandom_range(0, 20)));
        run_random(30, 1'b0);
        drain_results();
        set_config(3'b111, 1'b1, 16'd200, 16'd40, 16'd3);
        run_random(30, 1'b0);
        drain_results();

        if (events_due.size() != 0)
        begin
            mismatches += events_due.size();
            $display("%0d expected result beats never arrived", events_due.size());
        end
        $display("Sent %0d input beats over %0d register writes; checked %0d result beats.",
                 items_taken, reg_writes, beats_checked);
        $display("Settings ranged from all-zero timing to full-scale tolerance and delays.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
